// ===== design/tlp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlp_pkg
// shared types, constants and character helpers for the token list parser
// ----------------------------------------------------------------------------
package tlp_pkg;

  localparam int unsigned MAX_BODY_BYTES   = 4096;
  localparam int unsigned MAX_OPTION_BYTES = 16;

  localparam int unsigned POS_W     = 13;  // byte position, holds MAX_BODY_BYTES
  localparam int unsigned START_W   = 12;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned OPTLEN_W  = 5;
  localparam int unsigned OPT_W     = 8 * MAX_OPTION_BYTES;
  localparam int unsigned OPT_IDX_W = $clog2(MAX_OPTION_BYTES);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 64;

  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_BACKTICK   = 8'h60;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_TILDE      = 8'h7E;

  typedef enum logic [1:0] {
    ACT_BYTE      = 2'd0,
    ACT_BODY_END  = 2'd1,
    ACT_GROUP_END = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_TOKEN  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_GROUP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_OPT_LO  = 2'd0,
    REG_OPT_HI  = 2'd1,
    REG_OPT_LEN = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [OPT_W-1:0]    bytes;  // byte 0 in the low bits
    logic [OPTLEN_W-1:0] len;
  } opt_cfg_t;

  // work for the back end: an optional token, then an optional final result
  typedef struct packed {
    logic               tok;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               fin;
    kind_e              fin_kind;
    logic               ok;
    logic               found;
  } tlp_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tlp_qstat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_token_char(input logic [7:0] c);
    logic alnum;
    alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
            (c >= 8'h41 && c <= 8'h5A);
    return alnum || c == CH_DASH || c == CH_DOT || c == CH_BANG ||
           c == CH_PERCENT || c == CH_STAR || c == CH_UNDERSCORE ||
           c == CH_PLUS || c == CH_BACKTICK || c == CH_QUOTE || c == CH_TILDE;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

// ===== design/token_list_parser_matcher_core.sv =====
// ----------------------------------------------------------------------------
// token_list_parser_matcher_core
// comma-separated token list parser with case-insensitive option match
// ----------------------------------------------------------------------------
// Header body bytes stream in one item per cycle on the slave side; tuser
// carries the action (body byte, end of body, end of group). Every byte is
// classified and folded into the parser state in the cycle it is accepted,
// so input runs at one item per clock as long as the four-entry work queue
// has room. Items that produce results (a comma closing a token, an end of
// body, an end of group) drop one queue entry; the back end turns each
// entry into one or two result items through a registered output stage at
// one result per clock while the sink is ready, so an end of body that
// closes a pending token gives two results. Results: tuser is the kind
// (token, body status, group answer) and tlast marks the final result of
// an input item. Tokens come out as soon as they are closed; if the body
// later ends in error its status shows body_ok low and the consumer drops
// them. The option is programmed through the APB port (low bytes at 0x00,
// high bytes at 0x08, length at 0x10); the user must program it only while
// the stream is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module token_list_parser_matcher_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  // apb configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlp_pkg::APB_AW-1:0]   paddr,
  input  logic [tlp_pkg::APB_DW-1:0]   pwdata,
  output logic [tlp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,

  // input items
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // data_byte[7:0]
  input  logic [1:0]                   s_axis_tuser,   // action[1:0]

  // result items
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,   // tok_offset[11:0],
                                                       // token_length[24:12],
                                                       // body_ok[25],
                                                       // option_found[26]
  output logic [1:0]                   m_axis_tuser,   // kind[1:0]
  output logic                         m_axis_tlast    // last
);

  logic [63:0]                    opt_lo_q;
  logic [63:0]                    opt_hi_q;
  logic [tlp_pkg::OPTLEN_W-1:0]   opt_len_q;
  logic                           cfg_wr;
  logic [1:0]                     reg_idx;
  tlp_pkg::opt_cfg_t              opt_cfg;

  logic                           in_accept;
  logic                           push;
  tlp_pkg::tlp_desc_t             push_desc;
  tlp_pkg::tlp_desc_t             head;
  tlp_pkg::tlp_qstat_t            qstat;
  logic                           pop;

  // register file: index from the 8-byte slot, low address bits ignored
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_lo_q  <= '0;
      opt_hi_q  <= '0;
      opt_len_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        tlp_pkg::REG_OPT_LO:  opt_lo_q  <= pwdata;
        tlp_pkg::REG_OPT_HI:  opt_hi_q  <= pwdata;
        tlp_pkg::REG_OPT_LEN: opt_len_q <= pwdata[tlp_pkg::OPTLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tlp_pkg::REG_OPT_LO:  prdata = opt_lo_q;
      tlp_pkg::REG_OPT_HI:  prdata = opt_hi_q;
      tlp_pkg::REG_OPT_LEN: prdata = tlp_pkg::APB_DW'(opt_len_q);
      default:              prdata = '0;
    endcase
  end

  assign opt_cfg.bytes = {opt_hi_q, opt_lo_q};
  assign opt_cfg.len   = opt_len_q;

  // input is held off only when the work queue is full
  assign s_axis_tready = !qstat.full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  tlp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .action_i (s_axis_tuser),
    .data_i   (s_axis_tdata),
    .opt_i    (opt_cfg),
    .push_o   (push),
    .desc_o   (push_desc)
  );

  tlp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  tlp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== design/tlp_front.sv =====
// ----------------------------------------------------------------------------
// tlp_front
// per-byte parser: classifies each item, tracks the pending token and match
// ----------------------------------------------------------------------------
module tlp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    action_i,
  input  logic [7:0]                    data_i,
  input  tlp_pkg::opt_cfg_t             opt_i,
  output logic                          push_o,
  output tlp_pkg::tlp_desc_t            desc_o
);

  typedef enum logic [2:0] {
    PH_LEAD0,
    PH_LEAD_SP,
    PH_TOKEN,
    PH_TRAIL,
    PH_ERROR
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [tlp_pkg::POS_W-1:0]      bpos_q, bpos_d;
  logic [tlp_pkg::START_W-1:0]    pstart_q, pstart_d;
  logic [tlp_pkg::LEN_W-1:0]      plen_q, plen_d;
  logic                           pmatch_q, pmatch_d;
  logic                           body_match_q, body_match_d;
  logic                           group_match_q, group_match_d;

  logic [tlp_pkg::LEN_W-1:0]      cmp_idx;
  logic [7:0]                     opt_byte;
  logic                           byte_hit;
  logic                           tok_hit;
  logic                           body_ok;
  logic                           found;
  logic                           len_ok;

  // a new token compares from option byte zero, an extension at its length
  assign cmp_idx  = (phase_q == PH_TOKEN) ? plen_q : '0;
  assign opt_byte = opt_i.bytes[{cmp_idx[tlp_pkg::OPT_IDX_W-1:0], 3'b000} +: 8];
  assign byte_hit = (cmp_idx < tlp_pkg::LEN_W'(opt_i.len)) &&
                    (cmp_idx < tlp_pkg::LEN_W'(tlp_pkg::MAX_OPTION_BYTES)) &&
                    (tlp_pkg::to_lower(data_i) == tlp_pkg::to_lower(opt_byte));

  assign len_ok  = (opt_i.len != '0) &&
                   (opt_i.len <= tlp_pkg::OPTLEN_W'(tlp_pkg::MAX_OPTION_BYTES));
  assign tok_hit = pmatch_q && len_ok && (plen_q == tlp_pkg::LEN_W'(opt_i.len));
  assign body_ok = (phase_q == PH_LEAD0) || (phase_q == PH_TOKEN) ||
                   (phase_q == PH_TRAIL);
  assign found   = body_ok && (body_match_q ||
                   (((phase_q == PH_TOKEN) || (phase_q == PH_TRAIL)) && tok_hit));

  always_comb begin
    phase_d       = phase_q;
    bpos_d        = bpos_q;
    pstart_d      = pstart_q;
    plen_d        = plen_q;
    pmatch_d      = pmatch_q;
    body_match_d  = body_match_q;
    group_match_d = group_match_q;
    push_o        = 1'b0;
    desc_o        = '0;
    desc_o.fin_kind = tlp_pkg::KIND_TOKEN;

    if (accept_i) begin
      case (action_i)
        tlp_pkg::ACT_BYTE: begin
          if (bpos_q >= tlp_pkg::POS_W'(tlp_pkg::MAX_BODY_BYTES)) begin
            phase_d = PH_ERROR;
          end else begin
            bpos_d = bpos_q + 1'b1;
            case (phase_q)
              PH_LEAD0, PH_LEAD_SP, PH_TOKEN, PH_TRAIL: begin
                if (tlp_pkg::is_token_char(data_i)) begin
                  if (phase_q == PH_TOKEN) begin
                    pmatch_d = pmatch_q & byte_hit;
                    if (plen_q < tlp_pkg::LEN_W'(tlp_pkg::MAX_BODY_BYTES)) begin
                      plen_d = plen_q + 1'b1;
                    end
                  end else begin
                    pstart_d = bpos_q[tlp_pkg::START_W-1:0];
                    plen_d   = tlp_pkg::LEN_W'(1);
                    pmatch_d = byte_hit;
                  end
                  phase_d = PH_TOKEN;
                end else if (tlp_pkg::is_space(data_i)) begin
                  phase_d = (phase_q == PH_LEAD0 || phase_q == PH_LEAD_SP) ?
                            PH_LEAD_SP : PH_TRAIL;
                end else if (data_i == tlp_pkg::CH_COMMA &&
                             (phase_q == PH_TOKEN || phase_q == PH_TRAIL)) begin
                  push_o       = 1'b1;
                  desc_o.tok   = 1'b1;
                  desc_o.start = pstart_q;
                  desc_o.len   = plen_q;
                  body_match_d = body_match_q | tok_hit;
                  phase_d      = PH_LEAD0;
                end else begin
                  phase_d = PH_ERROR;
                end
              end
              default: phase_d = PH_ERROR;
            endcase
          end
        end
        tlp_pkg::ACT_BODY_END: begin
          push_o          = 1'b1;
          desc_o.tok      = (phase_q == PH_TOKEN) || (phase_q == PH_TRAIL);
          desc_o.start    = pstart_q;
          desc_o.len      = plen_q;
          desc_o.fin      = 1'b1;
          desc_o.fin_kind = tlp_pkg::KIND_STATUS;
          desc_o.ok       = body_ok;
          desc_o.found    = found;
          group_match_d   = group_match_q | found;
          phase_d         = PH_LEAD0;
          bpos_d          = '0;
          pstart_d        = '0;
          plen_d          = '0;
          pmatch_d        = 1'b1;
          body_match_d    = 1'b0;
        end
        tlp_pkg::ACT_GROUP_END: begin
          push_o          = 1'b1;
          desc_o.fin      = 1'b1;
          desc_o.fin_kind = tlp_pkg::KIND_GROUP;
          desc_o.found    = group_match_q;
          group_match_d   = 1'b0;
          phase_d         = PH_LEAD0;
          bpos_d          = '0;
          pstart_d        = '0;
          plen_d          = '0;
          pmatch_d        = 1'b1;
          body_match_d    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_LEAD0;
      bpos_q        <= '0;
      pstart_q      <= '0;
      plen_q        <= '0;
      pmatch_q      <= 1'b1;
      body_match_q  <= 1'b0;
      group_match_q <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      bpos_q        <= bpos_d;
      pstart_q      <= pstart_d;
      plen_q        <= plen_d;
      pmatch_q      <= pmatch_d;
      body_match_q  <= body_match_d;
      group_match_q <= group_match_d;
    end
  end

endmodule

// ===== design/tlp_queue.sv =====
// ----------------------------------------------------------------------------
// tlp_queue
// small queue of parser work between front and back end
// ----------------------------------------------------------------------------
module tlp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tlp_pkg::tlp_desc_t   desc_i,
  input  logic                 pop_i,
  output tlp_pkg::tlp_desc_t   head_o,
  output tlp_pkg::tlp_qstat_t  stat_o
);

  tlp_pkg::tlp_desc_t           mem_q [tlp_pkg::QUEUE_DEPTH];
  logic [tlp_pkg::QPTR_W-1:0]   wr_ptr_q;
  logic [tlp_pkg::QPTR_W-1:0]   rd_ptr_q;
  logic [tlp_pkg::QCNT_W-1:0]   cnt_q;
  logic                         do_pop;

  assign stat_o.full  = (cnt_q == tlp_pkg::QCNT_W'(tlp_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && !stat_o.empty;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + tlp_pkg::QCNT_W'(push_i) - tlp_pkg::QCNT_W'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("queue pushed while full");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tlp_pkg::QCNT_W'(tlp_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !stat_o.empty && !push_i) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue pop lost");
`endif

endmodule

// ===== design/tlp_back.sv =====
// ----------------------------------------------------------------------------
// tlp_back
// turns queued work into result items through a registered output stage
// ----------------------------------------------------------------------------
module tlp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlp_pkg::tlp_desc_t   head_i,
  input  tlp_pkg::tlp_qstat_t  qstat_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  logic                         vld_q;
  logic [1:0]                   kind_q;
  logic [tlp_pkg::START_W-1:0]  start_q;
  logic [tlp_pkg::LEN_W-1:0]    len_q;
  logic                         ok_q;
  logic                         found_q;
  logic                         last_q;
  logic                         hold_q;   // final result of a token+status pair waits
  tlp_pkg::tlp_desc_t           held_q;
  logic                         load;

  assign load  = !vld_q || m_axis_tready;
  assign pop_o = load && !hold_q && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      hold_q <= 1'b0;
    end else if (load) begin
      if (hold_q) begin
        vld_q  <= 1'b1;
        hold_q <= 1'b0;
      end else begin
        vld_q  <= !qstat_i.empty;
        hold_q <= !qstat_i.empty && head_i.tok && head_i.fin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (hold_q) begin
        kind_q  <= held_q.fin_kind;
        start_q <= '0;
        len_q   <= '0;
        ok_q    <= held_q.ok;
        found_q <= held_q.found;
        last_q  <= 1'b1;
      end else if (head_i.tok) begin
        kind_q  <= tlp_pkg::KIND_TOKEN;
        start_q <= head_i.start;
        len_q   <= head_i.len;
        ok_q    <= 1'b0;
        found_q <= 1'b0;
        last_q  <= !head_i.fin;
      end else begin
        kind_q  <= head_i.fin_kind;
        start_q <= '0;
        len_q   <= '0;
        ok_q    <= head_i.ok;
        found_q <= head_i.found;
        last_q  <= 1'b1;
      end
      held_q <= head_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {5'b0, found_q, ok_q, len_q, start_q};

`ifndef SYNTHESIS
  a_hold_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> vld_q)
    else $error("held final result without a pending output");
  a_hold_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> !pop_o)
    else $error("queue popped while a final result is held");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives header body bytes into the token list parser and checks every token,
// body status and group answer against a cycle-free model of the parser kept
// inside a small scoreboard class; the option register is reprogrammed
// between phases while the stream is idle
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // action code outside the defined set, the block drops such items
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES   = 6;   // quiet time once no result is owed
  localparam int unsigned MAX_PRINTED     = 50;

  // parser phase as the model tracks it
  typedef enum logic [2:0] {
    PH_LEAD0,
    PH_LEAD_SP,
    PH_TOKEN,
    PH_TRAIL,
    PH_ERROR
  } parse_phase_e;

  // one result item, all fields at the block's widths
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] tok_start;
    logic [12:0] tok_len;
    logic        body_ok;
    logic        found;
    logic        is_last;
  } parse_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: tracks the parser state per accepted item and holds the
  // results still owed by the block, oldest first
  // --------------------------------------------------------------------------
  class token_list_board;
    logic [63:0]   opt_lo;
    logic [63:0]   opt_hi;
    logic [4:0]    opt_len;
    parse_phase_e  phase;
    int unsigned   byte_pos;
    int unsigned   tok_start;
    int unsigned   tok_len;
    bit            tok_hit;
    bit            body_hit;
    bit            group_hit;
    parse_result_t due_q[$];
    int unsigned   n_errors;
    int unsigned   n_seen;

    function new();
      opt_lo    = '0;
      opt_hi    = '0;
      opt_len   = '0;
      group_hit = 1'b0;
      n_errors  = 0;
      n_seen    = 0;
      restart_body();
    endfunction

    task report(string msg);
      n_errors++;
      if (n_errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    function void set_register(tlp_pkg::reg_idx_e idx, logic [63:0] value);
      case (idx)
        tlp_pkg::REG_OPT_LO:  opt_lo = value;
        tlp_pkg::REG_OPT_HI:  opt_hi = value;
        tlp_pkg::REG_OPT_LEN: opt_len = value[4:0];
        default: ;
      endcase
    endfunction

    function int unsigned due_count();
      return due_q.size();
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit is_word_char(logic [7:0] c);
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A)) return 1'b1;
      return c == tlp_pkg::CH_DASH || c == tlp_pkg::CH_DOT || c == tlp_pkg::CH_BANG ||
             c == tlp_pkg::CH_PERCENT || c == tlp_pkg::CH_STAR ||
             c == tlp_pkg::CH_UNDERSCORE || c == tlp_pkg::CH_PLUS ||
             c == tlp_pkg::CH_BACKTICK || c == tlp_pkg::CH_QUOTE ||
             c == tlp_pkg::CH_TILDE;
    endfunction

    function logic [7:0] fold_case(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    function logic [7:0] opt_char(int unsigned i);
      if (i < 8) return opt_lo[8*i +: 8];
      if (i < 16) return opt_hi[8*(i-8) +: 8];
      return 8'h00;
    endfunction

    function void add_expected(logic [1:0] kind, int unsigned st, int unsigned ln,
                               bit ok, bit found, bit is_last);
      parse_result_t r;
      r.kind      = kind;
      r.tok_start = 12'(st);
      r.tok_len   = 13'(ln);
      r.body_ok   = ok;
      r.found     = found;
      r.is_last   = is_last;
      due_q.push_back(r);
    endfunction

    function void restart_body();
      phase     = PH_LEAD0;
      byte_pos  = 0;
      tok_start = 0;
      tok_len   = 0;
      tok_hit   = 1'b1;
      body_hit  = 1'b0;
    endfunction

    function void grow_token(logic [7:0] c);
      if (!(tok_len < opt_len && tok_len < tlp_pkg::MAX_OPTION_BYTES &&
            fold_case(c) == fold_case(opt_char(tok_len))))
        tok_hit = 1'b0;
      if (tok_len < tlp_pkg::MAX_BODY_BYTES) tok_len++;
    endfunction

    function void open_token(logic [7:0] c, int unsigned at);
      tok_start = at;
      tok_len   = 0;
      tok_hit   = 1'b1;
      grow_token(c);
      phase = PH_TOKEN;
    endfunction

    function void emit_token(bit is_last);
      if (tok_hit && opt_len != 0 && opt_len <= tlp_pkg::MAX_OPTION_BYTES &&
          tok_len == opt_len)
        body_hit = 1'b1;
      add_expected(tlp_pkg::KIND_TOKEN, tok_start, tok_len, 1'b0, 1'b0, is_last);
    endfunction

    function void take_byte(logic [7:0] c);
      int unsigned at;
      at = byte_pos;
      if (at >= tlp_pkg::MAX_BODY_BYTES) begin
        phase = PH_ERROR;
        return;
      end
      byte_pos = at + 1;
      case (phase)
        PH_LEAD0, PH_LEAD_SP: begin
          if (is_blank(c)) phase = PH_LEAD_SP;
          else if (is_word_char(c)) open_token(c, at);
          else phase = PH_ERROR;
        end
        PH_TOKEN, PH_TRAIL: begin
          if (is_word_char(c)) begin
            if (phase == PH_TOKEN) grow_token(c);
            else open_token(c, at);
          end else if (is_blank(c)) begin
            phase = PH_TRAIL;
          end else if (c == tlp_pkg::CH_COMMA) begin
            emit_token(1'b1);
            phase = PH_LEAD0;
          end else begin
            phase = PH_ERROR;
          end
        end
        default: phase = PH_ERROR;
      endcase
    endfunction

    function void close_body();
      bit ok;
      bit hit;
      if (phase == PH_TOKEN || phase == PH_TRAIL) emit_token(1'b0);
      ok  = phase == PH_LEAD0 || phase == PH_TOKEN || phase == PH_TRAIL;
      hit = ok && body_hit;
      if (hit) group_hit = 1'b1;
      add_expected(tlp_pkg::KIND_STATUS, 0, 0, ok, hit, 1'b1);
      restart_body();
    endfunction

    function void close_group();
      add_expected(tlp_pkg::KIND_GROUP, 0, 0, 1'b0, group_hit, 1'b1);
      restart_body();
      group_hit = 1'b0;
    endfunction

    function void note_item(logic [1:0] act, logic [7:0] c);
      case (act)
        tlp_pkg::ACT_BYTE:      take_byte(c);
        tlp_pkg::ACT_BODY_END:  close_body();
        tlp_pkg::ACT_GROUP_END: close_group();
        default: ;
      endcase
    endfunction

    task check_result(logic [1:0] kind, logic [31:0] data, logic is_last);
      parse_result_t got;
      parse_result_t want;
      got.kind      = kind;
      got.tok_start = data[11:0];
      got.tok_len   = data[24:12];
      got.body_ok   = data[25];
      got.found     = data[26];
      got.is_last   = is_last;
      n_seen++;
      if (due_q.size() == 0) begin
        report($sformatf("result %0d arrived with none due: kind %0d data %h last %b",
                         n_seen, kind, data, is_last));
        return;
      end
      want = due_q.pop_front();
      if (got !== want || data[31:27] !== 5'd0)
        report($sformatf({"result %0d: kind %0d/%0d start %0d/%0d len %0d/%0d ",
                          "ok %b/%b found %b/%b last %b/%b pad %b"},
                         n_seen, got.kind, want.kind, got.tok_start, want.tok_start,
                         got.tok_len, want.tok_len, got.body_ok, want.body_ok,
                         got.found, want.found, got.is_last, want.is_last,
                         data[31:27]));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [tlp_pkg::APB_AW-1:0]   paddr   = '0;
  logic [tlp_pkg::APB_DW-1:0]   pwdata  = '0;
  logic [tlp_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  token_list_parser_matcher_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  token_list_board board;

  // stimulus state shared by the sender tasks
  logic [7:0]  opt_txt [16];     // option text as the sender knows it
  int unsigned opt_txt_n    = 0;
  int unsigned items_sent   = 0; // items that the block does not ignore
  bit          sender_quiet = 1'b0;
  bit          burst_mode   = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          rx_quiet     = 1'b0;
  int unsigned idle_cycles  = 0;

  // unless quiet, half of the items go out back to back, the rest after a random idle gap
  function automatic int unsigned draw_gap(bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [7:0] word_char();
    int unsigned r;
    r = $urandom_range(0, 71);
    if (r < 10) return 8'h30 + 8'(r);
    if (r < 36) return 8'h61 + 8'(r - 10);
    if (r < 62) return 8'h41 + 8'(r - 36);
    case (r - 62)
      0: return tlp_pkg::CH_DASH;
      1: return tlp_pkg::CH_DOT;
      2: return tlp_pkg::CH_BANG;
      3: return tlp_pkg::CH_PERCENT;
      4: return tlp_pkg::CH_STAR;
      5: return tlp_pkg::CH_UNDERSCORE;
      6: return tlp_pkg::CH_PLUS;
      7: return tlp_pkg::CH_BACKTICK;
      8: return tlp_pkg::CH_QUOTE;
      default: return tlp_pkg::CH_TILDE;
    endcase
  endfunction

  // space or one of the control blanks tab through carriage return
  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
  endfunction

  // --------------------------------------------------------------------------
  // configuration port: write, then read the register back
  // --------------------------------------------------------------------------
  task automatic write_register(tlp_pkg::reg_idx_e idx, logic [63:0] value);
    logic [63:0] want;
    want = (idx == tlp_pkg::REG_OPT_LEN) ? {59'd0, value[4:0]} : value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_register(idx, value);
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      board.report($sformatf("register %0d reads %h, written %h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_option(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    write_register(tlp_pkg::REG_OPT_LO, lo);
    write_register(tlp_pkg::REG_OPT_HI, hi);
    write_register(tlp_pkg::REG_OPT_LEN, {59'd0, len});
  endtask

  // random option text of n word characters; bytes past the text stay random
  task automatic pick_option(int unsigned n, logic [4:0] len_reg);
    logic [127:0] raw;
    int unsigned  i;
    raw = {$urandom, $urandom, $urandom, $urandom};
    for (i = 0; i < n; i++) begin
      opt_txt[i]     = word_char();
      raw[8*i +: 8] = opt_txt[i];
    end
    opt_txt_n = n;
    set_option(raw[63:0], raw[127:64], len_reg);
  endtask

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] act, logic [7:0] c);
    int unsigned gap;
    gap = draw_gap(sender_quiet || burst_mode);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(act, c);
    if (act != ACT_IGNORED) items_sent++;
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(tlp_pkg::ACT_BYTE, s[i]);
  endtask

  task automatic send_word(int unsigned n);
    repeat (n) send_item(tlp_pkg::ACT_BYTE, word_char());
  endtask

  task automatic send_blanks(int unsigned n);
    repeat (n) send_item(tlp_pkg::ACT_BYTE, blank_char());
  endtask

  // marker items carry a random byte that the block must ignore
  task automatic end_body();
    send_item(tlp_pkg::ACT_BODY_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic end_group();
    send_item(tlp_pkg::ACT_GROUP_END, 8'($urandom_range(0, 255)));
  endtask

  // the option in random case, sometimes one short, one long or with its last
  // character replaced
  task automatic send_option_like();
    int unsigned i;
    int unsigned n;
    int unsigned variant;
    logic [7:0]  c;
    if (opt_txt_n == 0) begin
      send_word($urandom_range(1, 6));
      return;
    end
    variant = $urandom_range(0, 5);
    n = opt_txt_n;
    if (variant == 3 && n > 1) n--;
    for (i = 0; i < n; i++) begin
      c = opt_txt[i];
      if (variant == 5 && i == n - 1) c = word_char();
      if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1) == 1)
        c = c ^ 8'h20;
      send_item(tlp_pkg::ACT_BYTE, c);
    end
    if (variant == 4) send_item(tlp_pkg::ACT_BYTE, word_char());
  endtask

  // mostly well-formed lists with random content, plus some breakage
  task automatic send_body();
    int unsigned n_ent;
    int unsigned i;
    sender_quiet = ($urandom_range(0, 3) == 0);
    n_ent = $urandom_range(0, 4);
    // an empty list, sometimes made only of blanks (a parse error)
    if (n_ent == 0 && $urandom_range(0, 1) == 1) send_blanks($urandom_range(1, 3));
    for (i = 0; i < n_ent; i++) begin
      if ($urandom_range(0, 3) == 0) send_blanks($urandom_range(1, 2));
      if ($urandom_range(0, 2) == 0) send_option_like();
      else send_word($urandom_range(1, 6));
      // blanks then another token: the first one gets dropped
      if ($urandom_range(0, 9) == 0) begin
        send_blanks($urandom_range(1, 2));
        if ($urandom_range(0, 1) == 1) send_option_like();
        else send_word($urandom_range(1, 4));
      end
      if ($urandom_range(0, 3) == 0) send_blanks($urandom_range(1, 2));
      // noise: any byte, or an extra comma that leaves an empty list entry
      if ($urandom_range(0, 11) == 0)
        send_item(tlp_pkg::ACT_BYTE,
                  $urandom_range(0, 1) ? tlp_pkg::CH_COMMA : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 39) == 0) send_item(ACT_IGNORED, 8'($urandom_range(0, 255)));
      if (i + 1 < n_ent || $urandom_range(0, 4) == 0) begin
        send_item(tlp_pkg::ACT_BYTE, tlp_pkg::CH_COMMA);
        // blanks after the closing comma make the body fail
        if (i + 1 == n_ent && $urandom_range(0, 3) == 0) send_blanks(1);
      end
    end
    // now and then the group ends in the middle of a body
    if ($urandom_range(0, 19) == 0) end_group();
    else end_body();
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      repeat ($urandom_range(1, 4)) send_body();
      end_group();
    end
  endtask

  // the sink stops for a long while as a dense run of results comes in
  task automatic stall_output();
    burst_mode   = 1'b1;
    hold_off_req = 1'b1;
    repeat (24) begin
      send_word(1);
      send_item(tlp_pkg::ACT_BYTE, tlp_pkg::CH_COMMA);
    end
    end_body();
    burst_mode = 1'b0;
  endtask

  // hold the input until the block owes nothing, then let it settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.due_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // output side: ready with random gaps, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        gap          = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        gap = draw_gap(rx_quiet);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // watchdog on cycles without any accepted item or register access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: option "aB", matched regardless of case
    opt_txt[0] = 8'h61;
    opt_txt[1] = 8'h42;
    opt_txt_n  = 2;
    set_option(64'h4261, 64'd0, 5'd2);
    end_body();                                   // empty body is clean
    send_text("Ab ,x");                           // match, blank before comma, last token
    end_body();
    send_text("q r,");                            // q dropped, trailing comma is fine
    end_body();
    send_text(",");                               // empty list entry
    end_body();
    send_text("y, ");                             // blanks after the final comma
    end_body();
    send_item(tlp_pkg::ACT_BYTE, 8'h00);          // stray control byte
    send_item(tlp_pkg::ACT_BYTE, 8'hFF);          // non-ascii byte
    end_body();
    end_group();                                  // group saw the match
    send_text("zz");                              // group ends inside a body
    end_group();
    send_item(ACT_IGNORED, 8'hA5);                // unused action code
    wait_idle();

    // full 16-byte option, output back-pressure
    pick_option(16, 5'd16);
    run_random(300);
    stall_output();
    run_random(100);
    wait_idle();

    // single-byte option
    pick_option(1, 5'd1);
    run_random(300);
    wait_idle();

    // zero length never matches; the sender also pauses mid-phase
    set_option(64'd0, 64'd0, 5'd0);
    run_random(120);
    wait_idle();
    run_random(120);
    wait_idle();

    // all ones: length past the limit and bytes no token can hold
    set_option('1, '1, 5'd31);
    run_random(250);
    wait_idle();

    // sixteen matching bytes but length one too many
    pick_option(16, 5'd17);
    run_random(250);
    wait_idle();

    // mid-size option
    begin : mid_option
      int unsigned n;
      n = $urandom_range(2, 12);
      pick_option(n, 5'(n));
    end
    run_random(300);
    wait_idle();

    if (board.n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tlp_pkg.sv
design/tlp_front.sv
design/tlp_queue.sv
design/tlp_back.sv
design/token_list_parser_matcher_core.sv
tb/sv/testbench.sv
